>>> rtl/core/lhsd_pkg.sv
// lhsd_pkg: shared types and constants of the length-header string deframer
// command beats between front and back, status codes, state enums, header chars
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lhsd_pkg;

  localparam int CNT_W       = 6;
  localparam int IDX_W       = 5;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PW     = 1;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_LEN_OVF   = 3'd3,
    ST_EARLY_END = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_START,
    CMD_BYTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic             last;
    status_t          code;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_HEADER,
    FR_BODY,
    FR_ERROR
  } front_state_t;

  typedef enum logic [1:0] {
    BK_READY,
    BK_FETCH,
    BK_WALK,
    BK_ST4
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/lhsd_ram.sv
// lhsd_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lhsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/lhsd_front.sv
// lhsd_front: header parser; collects lengths into the table and turns hash,
// payload, error and early-end beats into commands for the back part
// depends on lhsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lhsd_front #(
  parameter int MAX_STRINGS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int AW          = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   message_end,
  input  wire logic                   fifo_full,
  input  wire logic                   fifo_empty,
  input  wire logic                   back_idle,
  output logic                        push,
  output lhsd_pkg::cmd_t              push_cmd,
  output logic                        tbl_we,
  output logic [AW-1:0]               tbl_waddr,
  output logic [LENGTH_BITS-1:0]      tbl_wdata
);

  localparam int VW = LENGTH_BITS + 4;

  lhsd_pkg::front_state_t           state, state_next;
  logic [LENGTH_BITS-1:0]           acc, acc_next;
  logic                             pend, pend_next;
  logic [lhsd_pkg::CNT_W-1:0]       cnt, cnt_next;

  logic [VW-1:0] acc_x;
  logic [VW-1:0] acc_v;
  logic [7:0]    digit;
  logic          ovf;

  // next decimal value, four spare bits catch overflow
  assign acc_x = VW'(acc);
  assign digit = data_byte - lhsd_pkg::CH_ZERO;
  assign acc_v = (acc_x << 3) + (acc_x << 1) + VW'(digit[3:0]);
  assign ovf   = |acc_v[VW-1:LENGTH_BITS];

  assign tbl_waddr = cnt[AW-1:0];
  assign tbl_wdata = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhsd_pkg::FR_HEADER;
      acc   <= '0;
      pend  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    logic             take;
    logic             fail;
    logic             is_hash;
    lhsd_pkg::status_t fcode;

    state_next = state;
    acc_next   = acc;
    pend_next  = pend;
    cnt_next   = cnt;
    push       = 1'b0;
    tbl_we     = 1'b0;
    fail       = 1'b0;
    is_hash    = 1'b0;
    fcode      = lhsd_pkg::ST_BAD_CHAR;

    push_cmd.kind  = lhsd_pkg::CMD_STATUS;
    push_cmd.data  = data_byte;
    push_cmd.last  = message_end;
    push_cmd.code  = lhsd_pkg::ST_OK;
    push_cmd.count = cnt;

    // header beats wait until the back has finished with the table
    case (state)
      lhsd_pkg::FR_HEADER: in_ready = fifo_empty && back_idle;
      lhsd_pkg::FR_BODY:   in_ready = !fifo_full;
      lhsd_pkg::FR_ERROR:  in_ready = 1'b1;
      default:             in_ready = 1'b0;
    endcase

    take = in_valid && in_ready;

    if (take) begin
      case (state)
        lhsd_pkg::FR_HEADER: begin
          if (data_byte inside {[lhsd_pkg::CH_ZERO:lhsd_pkg::CH_NINE]}) begin
            if (ovf) begin
              fail  = 1'b1;
              fcode = lhsd_pkg::ST_LEN_OVF;
            end else begin
              acc_next  = acc_v[LENGTH_BITS-1:0];
              pend_next = 1'b1;
            end
          end else if (data_byte == lhsd_pkg::CH_COMMA) begin
            if (!pend) begin
              fail  = 1'b1;
              fcode = lhsd_pkg::ST_BAD_CHAR;
            end else if (cnt >= lhsd_pkg::CNT_W'(MAX_STRINGS)) begin
              fail  = 1'b1;
              fcode = lhsd_pkg::ST_TOO_MANY;
            end else begin
              tbl_we    = 1'b1;
              cnt_next  = cnt + lhsd_pkg::CNT_W'(1);
              acc_next  = '0;
              pend_next = 1'b0;
            end
          end else if (data_byte == lhsd_pkg::CH_HASH) begin
            if (pend) begin
              fail  = 1'b1;
              fcode = lhsd_pkg::ST_BAD_CHAR;
            end else begin
              is_hash       = 1'b1;
              push          = 1'b1;
              push_cmd.kind = lhsd_pkg::CMD_START;
              state_next    = lhsd_pkg::FR_BODY;
            end
          end else begin
            fail  = 1'b1;
            fcode = lhsd_pkg::ST_BAD_CHAR;
          end

          if (fail) begin
            push          = 1'b1;
            push_cmd.code = fcode;
            state_next    = lhsd_pkg::FR_ERROR;
          end else if (message_end && !is_hash) begin
            push          = 1'b1;
            push_cmd.code = lhsd_pkg::ST_EARLY_END;
          end
        end
        lhsd_pkg::FR_BODY: begin
          push          = 1'b1;
          push_cmd.kind = lhsd_pkg::CMD_BYTE;
        end
        default: begin
        end
      endcase

      // end of message: parser starts over
      if (message_end) begin
        state_next = lhsd_pkg::FR_HEADER;
        acc_next   = '0;
        pend_next  = 1'b0;
        cnt_next   = '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lhsd_cmd_fifo.sv
// lhsd_cmd_fifo: two-entry command queue between front and back
// depends on lhsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lhsd_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lhsd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output lhsd_pkg::cmd_t      pop_cmd,
  output logic                empty
);

  lhsd_pkg::cmd_t                  mem [lhsd_pkg::FIFO_DEPTH];
  logic [lhsd_pkg::FIFO_PW-1:0]    wptr, rptr;
  logic [lhsd_pkg::FIFO_PW:0]      level;

  assign empty   = (level == '0);
  assign full    = (level == (lhsd_pkg::FIFO_PW+1)'(lhsd_pkg::FIFO_DEPTH));
  assign pop_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + lhsd_pkg::FIFO_PW'(1);
      end
      if (pop && !empty) begin
        rptr <= rptr + lhsd_pkg::FIFO_PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   level <= level + (lhsd_pkg::FIFO_PW+1)'(1);
        2'b01:   level <= level - (lhsd_pkg::FIFO_PW+1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lhsd_back.sv
// lhsd_back: executes commands; walks the length table, streams payload bytes,
// empty-string markers and status results into the output register
// depends on lhsd_pkg; reads the table through lhsd_ram
`timescale 1ns / 1ps
`default_nettype none

module lhsd_back #(
  parameter int MAX_STRINGS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int AW          = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  input  wire lhsd_pkg::cmd_t             cmd,
  output logic                            pop,
  output logic                            back_idle,
  output logic [AW-1:0]                   tbl_raddr,
  input  wire logic [LENGTH_BITS-1:0]     tbl_rdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_byte,
  output logic                            has_byte,
  output logic [lhsd_pkg::IDX_W-1:0]      string_index,
  output logic                            string_end,
  output lhsd_pkg::status_t               status,
  output logic                            run_last
);

  localparam int CW = lhsd_pkg::CNT_W;

  lhsd_pkg::back_state_t    state, state_next;
  logic [CW-1:0]            cur, cur_next;
  logic [CW-1:0]            count, count_next;
  logic [LENGTH_BITS-1:0]   rem, rem_next;
  logic [LENGTH_BITS-1:0]   cur_len, cur_len_next;
  logic                     last_f, last_f_next;

  logic                     slot_free;
  logic                     done_nxt;
  logic                     is_done;
  logic                     start;
  logic [CW:0]              raddr_sum;

  logic                     emit;
  logic [7:0]               e_byte;
  logic                     e_has;
  logic [lhsd_pkg::IDX_W-1:0] e_idx;
  logic                     e_end;
  lhsd_pkg::status_t        e_code;
  logic                     e_last;

  assign slot_free = !out_valid || out_ready;
  assign is_done   = (cur >= count);
  assign done_nxt  = (({1'b0, cur} + (CW+1)'(1)) >= {1'b0, count});
  assign back_idle = (state == lhsd_pkg::BK_READY);

  // table lookahead: outside BK_FETCH, read data holds the length of the string after cur
  assign raddr_sum = {1'b0, cur_next} + (CW+1)'(1);
  assign tbl_raddr = start ? '0 : raddr_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lhsd_pkg::BK_READY;
      cur       <= '0;
      count     <= '0;
      last_f    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      count  <= count_next;
      last_f <= last_f_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    cur_len <= cur_len_next;
    if (emit) begin
      out_byte     <= e_byte;
      has_byte     <= e_has;
      string_index <= e_idx;
      string_end   <= e_end;
      status       <= e_code;
      run_last     <= e_last;
    end
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    count_next   = count;
    rem_next     = rem;
    cur_len_next = cur_len;
    last_f_next  = last_f;
    pop          = 1'b0;
    start        = 1'b0;
    emit         = 1'b0;
    e_byte       = '0;
    e_has        = 1'b0;
    e_idx        = cur[lhsd_pkg::IDX_W-1:0];
    e_end        = 1'b0;
    e_code       = lhsd_pkg::ST_OK;
    e_last       = 1'b0;

    case (state)
      lhsd_pkg::BK_READY: begin
        if (cmd_valid) begin
          case (cmd.kind)
            lhsd_pkg::CMD_STATUS: begin
              if (slot_free) begin
                pop    = 1'b1;
                emit   = 1'b1;
                e_idx  = '0;
                e_code = cmd.code;
                e_last = 1'b1;
              end
            end
            lhsd_pkg::CMD_START: begin
              pop         = 1'b1;
              start       = 1'b1;
              cur_next    = '0;
              count_next  = cmd.count;
              last_f_next = cmd.last;
              state_next  = lhsd_pkg::BK_FETCH;
            end
            lhsd_pkg::CMD_BYTE: begin
              if (is_done) begin
                // trailing byte
                pop = 1'b1;
                if (cmd.last) begin
                  cur_next   = '0;
                  count_next = '0;
                end
              end else if (slot_free) begin
                pop    = 1'b1;
                emit   = 1'b1;
                e_byte = cmd.data;
                e_has  = 1'b1;
                if (rem <= LENGTH_BITS'(1)) begin
                  e_end        = 1'b1;
                  e_last       = done_nxt || (!cmd.last && (tbl_rdata != '0));
                  cur_next     = cur + CW'(1);
                  cur_len_next = tbl_rdata;
                  last_f_next  = cmd.last;
                  state_next   = lhsd_pkg::BK_WALK;
                end else begin
                  e_last   = !cmd.last;
                  rem_next = rem - LENGTH_BITS'(1);
                  if (cmd.last) begin
                    state_next = lhsd_pkg::BK_ST4;
                  end
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      lhsd_pkg::BK_FETCH: begin
        cur_len_next = tbl_rdata;
        state_next   = lhsd_pkg::BK_WALK;
      end
      lhsd_pkg::BK_WALK: begin
        if (is_done) begin
          state_next = lhsd_pkg::BK_READY;
          if (last_f) begin
            cur_next   = '0;
            count_next = '0;
          end
        end else if (cur_len == '0) begin
          if (slot_free) begin
            emit         = 1'b1;
            e_end        = 1'b1;
            e_last       = done_nxt || (!last_f && (tbl_rdata != '0));
            cur_next     = cur + CW'(1);
            cur_len_next = tbl_rdata;
          end
        end else begin
          rem_next   = cur_len;
          state_next = last_f ? lhsd_pkg::BK_ST4 : lhsd_pkg::BK_READY;
        end
      end
      lhsd_pkg::BK_ST4: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_code     = lhsd_pkg::ST_EARLY_END;
          e_last     = 1'b1;
          cur_next   = '0;
          count_next = '0;
          state_next = lhsd_pkg::BK_READY;
        end
      end
      default: begin
        state_next = lhsd_pkg::BK_READY;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/length_header_string_deframer.sv
// length_header_string_deframer: top level; front parser, command queue,
// back executor and the length table RAM
// depends on lhsd_pkg, lhsd_ram, lhsd_front, lhsd_cmd_fifo, lhsd_back
//
// usage
//   input channel (in_valid/in_ready): one beat per message byte, message_end
//   on the last byte of a message; the parser starts over after that beat
//   output channel (out_valid/out_ready): one beat per result; run_last marks
//   the last result that one input beat caused (a beat may cause none)
//   path: a taken payload byte passes a queue entry, then the output register
//   throughput: one beat per cycle for header digits/commas and for bytes
//   inside a string while the queue and back keep up; a string end takes the
//   back through BK_WALK, which also emits each empty string's marker, and '#'
//   through BK_FETCH and BK_WALK; a new message's first header byte waits until
//   the back has drained the previous message, since both use the length table
//   stall: a stalled receiver holds the output register; the two-entry queue
//   fills and then in_ready drops
//   reset: synchronous, clears the parser, queue and output valid; the table
//   keeps its contents and needs no clearing pass (only written entries are used)
`timescale 1ns / 1ps
`default_nettype none

module length_header_string_deframer #(
  parameter int MAX_STRINGS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        message_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic [4:0]       string_index,
  output logic             string_end,
  output logic [2:0]       status,
  output logic             run_last
);

  localparam int AW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;

  // front to queue
  logic                   push;
  lhsd_pkg::cmd_t         push_cmd;
  logic                   fifo_full;
  logic                   fifo_empty;

  // queue to back
  logic                   pop;
  lhsd_pkg::cmd_t         pop_cmd;
  logic                   back_idle;

  // length table ports
  logic                   tbl_we;
  logic [AW-1:0]          tbl_waddr;
  logic [LENGTH_BITS-1:0] tbl_wdata;
  logic [AW-1:0]          tbl_raddr;
  logic [LENGTH_BITS-1:0] tbl_rdata;

  lhsd_pkg::status_t      status_q;

  assign status = status_q;

  // header parsing, error latching, command generation
  lhsd_front #(
    .MAX_STRINGS (MAX_STRINGS),
    .LENGTH_BITS (LENGTH_BITS),
    .AW          (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .message_end (message_end),
    .fifo_full   (fifo_full),
    .fifo_empty  (fifo_empty),
    .back_idle   (back_idle),
    .push        (push),
    .push_cmd    (push_cmd),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata)
  );

  // decouples parsing from result generation
  lhsd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  // string lengths, written by the front during the header, read by the back
  lhsd_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_STRINGS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // payload streaming, empty markers, error and early-end status
  lhsd_back #(
    .MAX_STRINGS (MAX_STRINGS),
    .LENGTH_BITS (LENGTH_BITS),
    .AW          (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!fifo_empty),
    .cmd          (pop_cmd),
    .pop          (pop),
    .back_idle    (back_idle),
    .tbl_raddr    (tbl_raddr),
    .tbl_rdata    (tbl_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .string_index (string_index),
    .string_end   (string_end),
    .status       (status_q),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire

>>> sim/deframer_checker.sv
// deframer_checker: watches both channels of the length-header string deframer,
// predicts every result from the accepted input beats and compares them in order
// depends on lhsd_pkg
`timescale 1ns / 1ps

module deframer_checker #(
  parameter int MAX_STRINGS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       message_end,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       has_byte,
  input  wire logic [4:0] string_index,
  input  wire logic       string_end,
  input  wire logic [2:0] status,
  input  wire logic       run_last,
  output int              mismatches,
  output int              pending
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              has;
    logic [4:0]        idx;
    logic              str_end;
    lhsd_pkg::status_t code;
    logic              last;
  } string_beat_t;

  localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;

  parse_phase_t    phase;
  longint unsigned len_table [MAX_STRINGS];
  int              len_count;
  longint unsigned accum;
  bit              digits_seen;
  int              cur_str;
  longint unsigned bytes_left;
  bit              err_latched;
  string_beat_t    expected_beats [$];
  int              result_no;

  function automatic void clear_parser();
    phase       = PH_HEADER;
    len_count   = 0;
    accum       = 0;
    digits_seen = 1'b0;
    cur_str     = 0;
    bytes_left  = 0;
    err_latched = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] data, logic has, logic str_end,
                               lhsd_pkg::status_t code);
    string_beat_t r;
    r.data    = data;
    r.has     = has;
    r.idx     = 5'(cur_str);
    r.str_end = str_end;
    r.code    = code;
    r.last    = 1'b0;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  function automatic void raise_error(lhsd_pkg::status_t code);
    emit(8'h00, 1'b0, 1'b0, code);
    err_latched = 1'b1;
  endfunction

  // empty markers for zero-length strings, then load the next string or finish
  function automatic void open_next_string();
    while (cur_str < len_count && cur_str < MAX_STRINGS && len_table[cur_str] == 0) begin
      emit(8'h00, 1'b0, 1'b1, lhsd_pkg::ST_OK);
      cur_str++;
    end
    if (cur_str >= len_count || cur_str >= MAX_STRINGS) begin
      phase      = PH_DONE;
      bytes_left = 0;
    end else begin
      phase      = PH_PAYLOAD;
      bytes_left = len_table[cur_str];
    end
  endfunction

  function automatic void header_char(logic [7:0] b);
    longint unsigned v;
    if (b >= lhsd_pkg::CH_ZERO && b <= lhsd_pkg::CH_NINE) begin
      v = accum * 64'd10 + {56'd0, b - lhsd_pkg::CH_ZERO};
      if (v > LEN_LIMIT) begin
        raise_error(lhsd_pkg::ST_LEN_OVF);
      end else begin
        accum       = v;
        digits_seen = 1'b1;
      end
    end else if (b == lhsd_pkg::CH_COMMA) begin
      if (!digits_seen) begin
        raise_error(lhsd_pkg::ST_BAD_CHAR);
      end else if (len_count >= MAX_STRINGS) begin
        raise_error(lhsd_pkg::ST_TOO_MANY);
      end else begin
        len_table[len_count] = accum;
        len_count++;
        accum       = 0;
        digits_seen = 1'b0;
      end
    end else if (b == lhsd_pkg::CH_HASH) begin
      if (digits_seen) begin
        raise_error(lhsd_pkg::ST_BAD_CHAR);
      end else begin
        cur_str = 0;
        open_next_string();
      end
    end else begin
      raise_error(lhsd_pkg::ST_BAD_CHAR);
    end
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic last_b);
    int           mark;
    string_beat_t tail;
    mark = expected_beats.size();
    if (!err_latched) begin
      if (phase == PH_HEADER) begin
        header_char(b);
      end else if (phase == PH_PAYLOAD) begin
        if (bytes_left <= 1) begin
          emit(b, 1'b1, 1'b1, lhsd_pkg::ST_OK);
          cur_str++;
          open_next_string();
        end else begin
          emit(b, 1'b1, 1'b0, lhsd_pkg::ST_OK);
          bytes_left--;
        end
      end
    end
    if (last_b) begin
      if (!err_latched && phase != PH_DONE)
        emit(8'h00, 1'b0, 1'b0, lhsd_pkg::ST_EARLY_END);
      clear_parser();
    end
    if (expected_beats.size() > mark) begin
      tail      = expected_beats[expected_beats.size() - 1];
      tail.last = 1'b1;
      expected_beats[expected_beats.size() - 1] = tail;
    end
  endfunction

  function automatic string show(string_beat_t r);
    return $sformatf("{byte %02h has %0b idx %0d end %0b status %0d last %0b}",
                     r.data, r.has, r.idx, r.str_end, r.code, r.last);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns deframer mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result();
    string_beat_t got;
    string_beat_t want;
    string        diffs;
    got.data    = out_byte;
    got.has     = has_byte;
    got.idx     = string_index;
    got.str_end = string_end;
    got.code    = lhsd_pkg::status_t'(status);
    got.last    = run_last;
    result_no++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected: %s", result_no, show(got)));
    end else begin
      want  = expected_beats.pop_front();
      diffs = "";
      if (got.data !== want.data)       diffs = {diffs, " out_byte"};
      if (got.has !== want.has)         diffs = {diffs, " has_byte"};
      if (got.idx !== want.idx)         diffs = {diffs, " string_index"};
      if (got.str_end !== want.str_end) diffs = {diffs, " string_end"};
      if (got.code !== want.code)       diffs = {diffs, " status"};
      if (got.last !== want.last)       diffs = {diffs, " run_last"};
      if (diffs != "")
        report_mismatch($sformatf("result %0d wrong%s: got %s want %s",
                                  result_no, diffs, show(got), show(want)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_beats.delete();
      result_no  = 0;
      mismatches = 0;
      pending   <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_beat(data_byte, message_end);
      if (out_valid && out_ready)
        check_result();
      pending <= expected_beats.size();
    end
  end

endmodule

>>> sim/tb_length_header_string_deframer.sv
// tb_length_header_string_deframer: stimulus and verdict for the deframer;
// sends directed and random encoded messages, stalls the result side at random
// depends on lhsd_pkg, length_header_string_deframer, deframer_checker
`timescale 1ns / 1ps

module tb_length_header_string_deframer;

  // generous bound on the run, many times the real work
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 220;
  // output register plus two-entry queue, with room for a stalled receiver
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_STRINGS_TB = 32;

  // receiver behaviors, switched whenever rx_tick wraps to zero
  typedef enum int {
    RX_FLOW,
    RX_COIN,
    RX_TRICKLE,
    RX_PERIODIC
  } rx_mode_t;

  // shapes of the generated messages
  typedef enum int {
    MK_GOOD,
    MK_BAD_CHAR,
    MK_EMPTY_LEN,
    MK_UNENDED,
    MK_OVERFLOW,
    MK_MAX_LEN,
    MK_EMPTY_RUN,
    MK_NOISE
  } msg_kind_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       message_end = 1'b0;
  logic       out_ready   = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_byte;
  logic [4:0] string_index;
  logic       string_end;
  logic [2:0] status;
  logic       run_last;

  int         mismatches;
  int         pending;

  int         burst_left  = 0;
  int         cycle_count = 0;
  rx_mode_t   rx_mode     = RX_FLOW;
  logic [5:0] rx_tick     = 6'd0;

  // bytes of the message being assembled
  logic [7:0] msg_bytes [$];

  length_header_string_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .string_index (string_index),
    .string_end   (string_end),
    .status       (status),
    .run_last     (run_last)
  );

  deframer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .string_index (string_index),
    .string_end   (string_end),
    .status       (status),
    .run_last     (run_last),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: a new stall pattern is picked each time rx_tick wraps
  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0)
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FLOW:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_TRICKLE:  out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= (rx_tick % 6'd3 != 6'd0);
    endcase
  end

  // one byte onto the end of the message being assembled
  function automatic void append_byte(logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  // decimal length text, optionally with a leading zero
  function automatic void push_decimal(int unsigned v, bit pad);
    logic [7:0]  digs [$];
    int unsigned rest;
    rest = v;
    do begin
      digs.push_front(lhsd_pkg::CH_ZERO + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    if (pad)
      digs.push_front(lhsd_pkg::CH_ZERO);
    foreach (digs[i])
      append_byte(digs[i]);
  endfunction

  function automatic void push_length(int unsigned v);
    push_decimal(v, $urandom_range(0, 9) == 0);
    append_byte(lhsd_pkg::CH_COMMA);
  endfunction

  // mostly short strings, now and then a longer one
  function automatic int unsigned pick_length(bit zero_heavy);
    int r;
    r = $urandom_range(0, 19);
    if (zero_heavy)
      return (r < 17) ? 0 : $urandom_range(1, 3);
    if (r < 5)
      return 0;
    if (r < 15)
      return $urandom_range(1, 4);
    if (r < 18)
      return $urandom_range(5, 16);
    return $urandom_range(17, 60);
  endfunction

  // n lengths with their commas; returns the payload size they announce
  function automatic int unsigned push_lengths(int n, bit zero_heavy);
    int unsigned total;
    int unsigned len;
    total = 0;
    for (int i = 0; i < n; i++) begin
      len = pick_length(zero_heavy);
      push_length(len);
      total += len;
    end
    return total;
  endfunction

  function automatic void push_random(int n);
    for (int i = 0; i < n; i++)
      append_byte(8'($urandom_range(0, 255)));
  endfunction

  // any header byte other than a digit, comma or hash
  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = 8'h00;
      1: c = 8'hFF;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= lhsd_pkg::CH_ZERO && c <= lhsd_pkg::CH_NINE) ||
               c == lhsd_pkg::CH_COMMA || c == lhsd_pkg::CH_HASH);
      end
    endcase
    return c;
  endfunction

  function automatic msg_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return MK_GOOD;
    if (r < 63) return MK_BAD_CHAR;
    if (r < 68) return MK_EMPTY_LEN;
    if (r < 73) return MK_UNENDED;
    if (r < 78) return MK_OVERFLOW;
    if (r < 83) return MK_MAX_LEN;
    if (r < 92) return MK_EMPTY_RUN;
    return MK_NOISE;
  endfunction

  // assembles one message; returns roughly how many of its beats the parser acts on
  // (trailing bytes added after an error byte or after the last string are left out)
  function automatic int build_message(int msg_no);
    int unsigned total;
    int          counted;
    int          keep;
    int          r;
    if (msg_no == 0) begin
      // full table: 32 strings, string index runs up to 31
      total = push_lengths(MAX_STRINGS_TB, 1'b1);
      append_byte(lhsd_pkg::CH_HASH);
      push_random(total);
      return msg_bytes.size();
    end
    if (msg_no == 2) begin
      // one length too many
      void'(push_lengths(MAX_STRINGS_TB, 1'b1));
      push_length(1);
      counted = msg_bytes.size();
      append_byte(lhsd_pkg::CH_HASH);
      return counted;
    end
    case (pick_kind())
      MK_GOOD: begin
        total = push_lengths(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5), 1'b0);
        append_byte(lhsd_pkg::CH_HASH);
        push_random(total);
        counted = msg_bytes.size();
        r = $urandom_range(0, 9);
        if (r < 3) begin
          // cut short somewhere: early end unless the cut hits the very end
          keep = $urandom_range(1, msg_bytes.size());
          while (msg_bytes.size() > keep)
            void'(msg_bytes.pop_back());
          counted = keep;
        end else if (r < 5) begin
          push_random($urandom_range(1, 3));
        end
      end
      MK_BAD_CHAR: begin
        void'(push_lengths($urandom_range(0, 3), 1'b0));
        append_byte(pick_bad_char());
        counted = msg_bytes.size();
        push_random($urandom_range(0, 3));
      end
      MK_EMPTY_LEN: begin
        void'(push_lengths($urandom_range(0, 3), 1'b0));
        append_byte(lhsd_pkg::CH_COMMA);
        counted = msg_bytes.size();
        push_random($urandom_range(0, 3));
      end
      MK_UNENDED: begin
        void'(push_lengths($urandom_range(0, 3), 1'b0));
        push_decimal(pick_length(1'b0), 1'b0);
        append_byte(lhsd_pkg::CH_HASH);
        counted = msg_bytes.size();
        push_random($urandom_range(0, 3));
      end
      MK_OVERFLOW: begin
        void'(push_lengths($urandom_range(0, 2), 1'b0));
        push_decimal($urandom_range(65536, 999999), 1'b0);
        append_byte(lhsd_pkg::CH_COMMA);
        counted = msg_bytes.size();
      end
      MK_MAX_LEN: begin
        // largest length accepted; the message ends inside that string
        total = push_lengths($urandom_range(0, 2), 1'b0);
        push_length(65535);
        append_byte(lhsd_pkg::CH_HASH);
        push_random(total + $urandom_range(0, 5));
        counted = msg_bytes.size();
      end
      MK_EMPTY_RUN: begin
        total = push_lengths($urandom_range(6, MAX_STRINGS_TB), 1'b1);
        append_byte(lhsd_pkg::CH_HASH);
        push_random(total);
        counted = msg_bytes.size();
      end
      default: begin
        push_random($urandom_range(1, 6));
        counted = msg_bytes.size();
      end
    endcase
    return counted;
  endfunction

  // one beat; valid stays up through bursts and drops only for a gap
  task automatic send_beat(logic [7:0] b, logic last_b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    data_byte   <= b;
    message_end <= last_b;
    do @(posedge clk); while (!in_ready);
  endtask

  // message_end rides on the final byte
  task automatic send_message();
    foreach (msg_bytes[i])
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // sender goes quiet until every predicted result has been seen
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int random_items;
    int msg_no;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hash alone: no lengths, the message is complete with no results
    append_byte(lhsd_pkg::CH_HASH);
    send_message();

    // an empty string and a two-byte string with extreme bytes, then a trailing byte
    push_decimal(0, 1'b0);
    append_byte(lhsd_pkg::CH_COMMA);
    push_decimal(2, 1'b0);
    append_byte(lhsd_pkg::CH_COMMA);
    append_byte(lhsd_pkg::CH_HASH);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'h41);
    send_message();

    // bad header char on the last byte: no early-end status after an error
    append_byte(8'hFF);
    send_message();

    // comma with no digits before it
    append_byte(lhsd_pkg::CH_COMMA);
    append_byte(lhsd_pkg::CH_HASH);
    send_message();

    // digit run closed by hash instead of a comma
    push_decimal(5, 1'b0);
    append_byte(lhsd_pkg::CH_HASH);
    send_message();

    // one past the largest length
    push_decimal(65536, 1'b0);
    append_byte(lhsd_pkg::CH_COMMA);
    send_message();

    // message ends inside the header
    push_decimal(1, 1'b0);
    send_message();

    // message ends inside a string
    push_decimal(3, 1'b0);
    append_byte(lhsd_pkg::CH_COMMA);
    append_byte(lhsd_pkg::CH_HASH);
    append_byte(8'h5A);
    send_message();

    // random messages, mostly well formed
    random_items = 0;
    msg_no       = 0;
    while (random_items < RANDOM_ITEMS) begin
      random_items += build_message(msg_no);
      if (msg_no == 1)
        hold_until_drained();
      send_message();
      msg_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/lhsd_pkg.sv
rtl/core/lhsd_ram.sv
rtl/core/lhsd_front.sv
rtl/core/lhsd_cmd_fifo.sv
rtl/core/lhsd_back.sv
rtl/core/length_header_string_deframer.sv
sim/deframer_checker.sv
sim/tb_length_header_string_deframer.sv
